[src/address_text_syntax_checker_assert.svh]
// Assertion macros for the address text checker.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
// The module that includes this file must have signals named clock and reset.
`ifndef ADDRESS_TEXT_SYNTAX_CHECKER_ASSERT_SVH
`define ADDRESS_TEXT_SYNTAX_CHECKER_ASSERT_SVH

// The condition holds in the same cycle as the trigger.
`define ATSC_ASSERT_SAME(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The condition holds in the cycle after the trigger.
`define ATSC_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

[src/atsc_pkg.sv]
`timescale 1ns / 1ps

package atsc_pkg;

   localparam int CHAR_W = 8;
   localparam int MASK_W = 3;
   localparam int ERR_W  = 8;
   localparam int KIND_W = 2;

   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

   // check_mask bit positions
   localparam int MASK_IPV4 = 0;
   localparam int MASK_HOST = 1;
   localparam int MASK_IPV6 = 2;
   localparam logic [MASK_W-1:0] MASK_RESET = 3'b111;

   localparam int OCTET_MAX    = 255;
   localparam int V4_SPAN_MAX  = 3;   // max distance from last dot to a digit
   localparam int V4_DOTS_REQ  = 3;
   localparam int V4_DOTS_SAT  = 7;
   localparam int V6_SPAN_MAX  = 4;   // max distance from last colon to a hex digit
   localparam int V6_COLON_MAX = 7;
   localparam int V6_COLON_MIN = 2;
   localparam int HOST_TLD_MIN = 3;   // last dot plus this must not exceed length plus one

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE = 2'd0,
      KIND_IPV4 = 2'd1,
      KIND_HOST = 2'd2,
      KIND_IPV6 = 2'd3
   } kind_type;

   typedef struct packed {
      logic       is_dot;
      logic       is_colon;
      logic       is_digit;
      logic       is_alpha;
      logic       is_xdigit;
      logic       is_graph;
      logic [3:0] digit_value;
   } char_class_type;

endpackage

[src/atsc_req_if.sv]
`timescale 1ns / 1ps

interface atsc_req_if import atsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic              end_of_text;

   modport source (output valid, char_code, end_of_text, input ready);
   modport sink (input valid, char_code, end_of_text, output ready);
endinterface

[src/atsc_rsp_if.sv]
`timescale 1ns / 1ps

interface atsc_rsp_if import atsc_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ERR_W-1:0]  error_position;
   logic [KIND_W-1:0] matched_kind;
   logic              too_long;

   modport source (output valid, error_position, matched_kind, too_long, input ready);
   modport sink (input valid, error_position, matched_kind, too_long, output ready);
endinterface

[src/address_text_syntax_checker.sv]
`timescale 1ns / 1ps
// Latency: a character word updates the checker state at its accept edge and yields no result;
//   an end-of-text word is evaluated at its accept edge and its result is valid the next cycle.
// Throughput: one word per cycle; the only stall is a held result that rsp has not taken.
// Reset: synchronous, active high; check_mask returns to 3'b111, all checkers clear and the
//   result register empties. No clearing pass, the block takes words the cycle after reset.

module address_text_syntax_checker import atsc_pkg::*; #(
   parameter int MAX_LEN = 255
) (
   input  logic              clock,
   input  logic              reset,
   atsc_req_if.sink          req_chan,
   atsc_rsp_if.source        rsp_chan,
   input  logic              csr_wr_en,
   input  logic [MASK_W-1:0] csr_wr_data
);

`include "address_text_syntax_checker_assert.svh"

   // Positions run 1..MAX_LEN+1; MAX_LEN+1 marks a full text.
   localparam int POS_W = $clog2(MAX_LEN + 2);
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_ZERO = '0;
   localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_LEN);
   localparam logic [POS_W-1:0] POS_FULL = POS_W'(MAX_LEN + 1);

   // ---------------------------------------------------------------------------
   // Handshake. A character word only touches the running state, but an
   // end word needs the result register, so ready follows the output slot.
   // ---------------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic fire, char_fire, end_fire;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = req_chan.valid && req_chan.ready;
   assign char_fire      = fire && !req_chan.end_of_text;
   assign end_fire       = fire && req_chan.end_of_text;

   char_class_type cls;

   atsc_char_class u_class (
      .char_code (req_chan.char_code),
      .cls       (cls)
   );

   // ---------------------------------------------------------------------------
   // Configuration
   // ---------------------------------------------------------------------------
   logic [MASK_W-1:0] mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_wr_en) begin
         mask_ff <= csr_wr_data;
      end
   end

   // ---------------------------------------------------------------------------
   // Character position, saturating at MAX_LEN once the text is full
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             ovf_ff, ovf_in;
   logic             full;
   logic [POS_W-1:0] cur_pos;

   assign full    = (pos_ff > POS_MAX);
   assign cur_pos = full ? POS_MAX : pos_ff;

   always_comb begin
      pos_in = pos_ff;
      ovf_in = ovf_ff;
      priority if (end_fire) begin
         pos_in = POS_ONE;
         ovf_in = 1'b0;
      end else if (char_fire) begin
         if (full) begin
            ovf_in = 1'b1;
         end else begin
            pos_in = pos_ff + POS_ONE;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // IPv4 checker: dotted decimal, octets up to 255
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0] v4_err_ff, v4_err_in;
   logic             v4_after_ff, v4_after_in;
   logic [POS_W-1:0] v4_last_ff, v4_last_in;
   logic [8:0]       v4_octet_ff, v4_octet_in;
   logic [2:0]       v4_dots_ff, v4_dots_in;
   logic [11:0]      v4_next_octet;

   assign v4_next_octet = 12'(v4_octet_ff) * 12'd10 + 12'(cls.digit_value);

   always_comb begin
      v4_err_in   = v4_err_ff;
      v4_after_in = v4_after_ff;
      v4_last_in  = v4_last_ff;
      v4_octet_in = v4_octet_ff;
      v4_dots_in  = v4_dots_ff;
      priority if (end_fire) begin
         v4_err_in   = POS_ZERO;
         v4_after_in = 1'b1;
         v4_last_in  = POS_ONE;
         v4_octet_in = '0;
         v4_dots_in  = '0;
      end else if (char_fire && (v4_err_ff == POS_ZERO)) begin
         if (cls.is_dot) begin
            if (v4_after_ff) begin
               v4_err_in = cur_pos;          // empty octet, leading dot included
            end else begin
               v4_after_in = 1'b1;
               v4_last_in  = cur_pos;
               v4_octet_in = '0;
               if (v4_dots_ff < 3'(V4_DOTS_SAT)) begin
                  v4_dots_in = v4_dots_ff + 3'd1;
               end
            end
         end else begin
            v4_after_in = 1'b0;
            priority if (!cls.is_digit) begin
               v4_err_in = cur_pos;
            end else if ((cur_pos - v4_last_ff) > POS_W'(V4_SPAN_MAX)) begin
               v4_err_in = cur_pos;
            end else if (v4_next_octet > 12'(OCTET_MAX)) begin
               v4_err_in = cur_pos;
            end else begin
               v4_octet_in = v4_next_octet[8:0];
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Hostname checker: printable labels, alphabetic last label
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0] host_err_ff, host_err_in;
   logic             host_after_ff, host_after_in;
   logic             host_alpha_ff, host_alpha_in;
   logic [POS_W-1:0] host_last_ff, host_last_in;

   always_comb begin
      host_err_in   = host_err_ff;
      host_after_in = host_after_ff;
      host_alpha_in = host_alpha_ff;
      host_last_in  = host_last_ff;
      priority if (end_fire) begin
         host_err_in   = POS_ZERO;
         host_after_in = 1'b1;
         host_alpha_in = 1'b1;
         host_last_in  = POS_ONE;
      end else if (char_fire && (host_err_ff == POS_ZERO)) begin
         if (cls.is_dot) begin
            if (host_after_ff) begin
               host_err_in = cur_pos;
            end else begin
               host_after_in = 1'b1;
               host_alpha_in = 1'b1;
               host_last_in  = cur_pos;
            end
         end else begin
            host_after_in = 1'b0;
            if (!cls.is_graph) begin
               host_err_in = cur_pos;
            end else if (!cls.is_alpha) begin
               host_alpha_in = 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // IPv6 checker: hex groups of up to four digits, at most one "::" gap
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0] v6_err_ff, v6_err_in;
   logic             v6_after_ff, v6_after_in;
   logic [POS_W-1:0] v6_last_ff, v6_last_in;
   logic [POS_W-1:0] v6_gap_ff, v6_gap_in;
   logic [3:0]       v6_colons_ff, v6_colons_in;
   logic [3:0]       v6_colons_inc;

   assign v6_colons_inc = v6_colons_ff + 4'd1;

   always_comb begin
      v6_err_in    = v6_err_ff;
      v6_after_in  = v6_after_ff;
      v6_last_in   = v6_last_ff;
      v6_gap_in    = v6_gap_ff;
      v6_colons_in = v6_colons_ff;
      priority if (end_fire) begin
         v6_err_in    = POS_ZERO;
         v6_after_in  = 1'b0;
         v6_last_in   = POS_ZERO;
         v6_gap_in    = POS_ZERO;
         v6_colons_in = '0;
      end else if (char_fire && (v6_err_ff == POS_ZERO)) begin
         if (cls.is_colon) begin
            if (v6_after_ff && (v6_gap_ff != POS_ZERO)) begin
               v6_err_in = cur_pos;          // second gap
            end else begin
               if (v6_after_ff) begin
                  v6_gap_in = cur_pos;
               end
               v6_after_in  = 1'b1;
               v6_last_in   = cur_pos;
               v6_colons_in = v6_colons_inc;
               if (v6_colons_inc > 4'(V6_COLON_MAX)) begin
                  v6_err_in = cur_pos;
               end
            end
         end else begin
            v6_after_in = 1'b0;
            if (!cls.is_xdigit) begin
               v6_err_in = cur_pos;
            end else if ((cur_pos - v6_last_ff) > POS_W'(V6_SPAN_MAX)) begin
               v6_err_in = cur_pos;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // End-of-text verdicts. n is the saturated length; an empty text fails
   // every check at position 1.
   // ---------------------------------------------------------------------------
   logic [POS_W-1:0] len_n;
   logic [POS_W:0]   host_len_plus;
   logic [POS_W:0]   host_dot_plus;
   logic [POS_W-1:0] v4_fin, host_fin, v6_fin;
   logic [POS_W-1:0] v4_e, host_e, v6_e, worst;
   logic             v4_pass, host_pass, v6_pass;
   kind_type         kind_in;
   logic [ERR_W-1:0] err_in;

   assign len_n         = pos_ff - POS_ONE;
   assign host_len_plus = {1'b0, len_n} + (POS_W+1)'(1);
   assign host_dot_plus = {1'b0, host_last_ff} + (POS_W+1)'(HOST_TLD_MIN);

   always_comb begin
      priority if (len_n == POS_ZERO)                v4_fin = POS_ONE;
      else if (v4_err_ff != POS_ZERO)                v4_fin = v4_err_ff;
      else if (v4_after_ff)                          v4_fin = len_n;
      else if (v4_dots_ff != 3'(V4_DOTS_REQ))        v4_fin = len_n;
      else                                           v4_fin = POS_ZERO;

      // A short or non-alphabetic last label is blamed on its dot.
      priority if (len_n == POS_ZERO)                host_fin = POS_ONE;
      else if (host_err_ff != POS_ZERO)              host_fin = host_err_ff;
      else if (host_after_ff)                        host_fin = len_n;
      else if (!host_alpha_ff)                       host_fin = host_last_ff;
      else if ((host_last_ff != POS_ONE) && (host_len_plus < host_dot_plus))
                                                     host_fin = host_last_ff;
      else                                           host_fin = POS_ZERO;

      // A trailing colon is fine only when it closes the "::" gap.
      priority if (len_n == POS_ZERO)                v6_fin = POS_ONE;
      else if (v6_err_ff != POS_ZERO)                v6_fin = v6_err_ff;
      else if (v6_after_ff && (v6_gap_ff != len_n))  v6_fin = len_n;
      else if (v6_colons_ff < 4'(V6_COLON_MIN))      v6_fin = len_n;
      else if ((v6_gap_ff == POS_ZERO) && (v6_colons_ff < 4'(V6_COLON_MAX)))
                                                     v6_fin = len_n;
      else                                           v6_fin = POS_ZERO;
   end

   always_comb begin
      v4_e      = mask_ff[MASK_IPV4] ? v4_fin   : POS_ZERO;
      host_e    = mask_ff[MASK_HOST] ? host_fin : POS_ZERO;
      v6_e      = mask_ff[MASK_IPV6] ? v6_fin   : POS_ZERO;
      v4_pass   = mask_ff[MASK_IPV4] && (v4_fin == POS_ZERO);
      host_pass = mask_ff[MASK_HOST] && (host_fin == POS_ZERO);
      v6_pass   = mask_ff[MASK_IPV6] && (v6_fin == POS_ZERO);

      worst = host_e;
      if (v4_e > worst) worst = v4_e;
      if (v6_e > worst) worst = v6_e;

      priority if (v4_pass)   kind_in = KIND_IPV4;
      else if (host_pass)     kind_in = KIND_HOST;
      else if (v6_pass)       kind_in = KIND_IPV6;
      else                    kind_in = KIND_NONE;

      // Wide MAX_LEN: only the low byte of the position is reported.
      err_in = (kind_in == KIND_NONE) ? ERR_W'(worst) : '0;
   end

   // ---------------------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------------------
   logic [ERR_W-1:0] err_ff;
   kind_type         kind_ff;
   logic             too_long_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (end_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (end_fire) begin
         err_ff      <= err_in;
         kind_ff     <= kind_in;
         too_long_ff <= ovf_ff;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.error_position = err_ff;
   assign rsp_chan.matched_kind   = kind_ff;
   assign rsp_chan.too_long       = too_long_ff;

   // ---------------------------------------------------------------------------
   // State registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pos_ff        <= POS_ONE;
         ovf_ff        <= 1'b0;
         v4_err_ff     <= POS_ZERO;
         v4_after_ff   <= 1'b1;
         v4_last_ff    <= POS_ONE;
         v4_octet_ff   <= '0;
         v4_dots_ff    <= '0;
         host_err_ff   <= POS_ZERO;
         host_after_ff <= 1'b1;
         host_alpha_ff <= 1'b1;
         host_last_ff  <= POS_ONE;
         v6_err_ff     <= POS_ZERO;
         v6_after_ff   <= 1'b0;
         v6_last_ff    <= POS_ZERO;
         v6_gap_ff     <= POS_ZERO;
         v6_colons_ff  <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pos_ff        <= pos_in;
         ovf_ff        <= ovf_in;
         v4_err_ff     <= v4_err_in;
         v4_after_ff   <= v4_after_in;
         v4_last_ff    <= v4_last_in;
         v4_octet_ff   <= v4_octet_in;
         v4_dots_ff    <= v4_dots_in;
         host_err_ff   <= host_err_in;
         host_after_ff <= host_after_in;
         host_alpha_ff <= host_alpha_in;
         host_last_ff  <= host_last_in;
         v6_err_ff     <= v6_err_in;
         v6_after_ff   <= v6_after_in;
         v6_last_ff    <= v6_last_in;
         v6_gap_ff     <= v6_gap_in;
         v6_colons_ff  <= v6_colons_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   `ATSC_ASSERT_NEXT(a_char_no_result, char_fire && !rsp_valid_ff, !rsp_valid_ff,
                     "character word produced a result")
   `ATSC_ASSERT_NEXT(a_end_result_clear, end_fire, rsp_valid_ff && (pos_ff == POS_ONE),
                     "end word did not post a result and clear the position")
   `ATSC_ASSERT_SAME(a_match_zero_err, rsp_valid_ff && (kind_ff != KIND_NONE),
                     err_ff == '0, "accepted text reports a nonzero error position")
   `ATSC_ASSERT_SAME(a_pos_range, 1'b1, (pos_ff >= POS_ONE) && (pos_ff <= POS_FULL),
                     "character position out of range")
   `ATSC_ASSERT_SAME(a_ovf_full, ovf_ff, pos_ff == POS_FULL,
                     "overflow flagged before the text was full")
   `ATSC_ASSERT_NEXT(a_v4_err_latched, (v4_err_ff != POS_ZERO) && !end_fire,
                     v4_err_ff == $past(v4_err_ff), "IPv4 first error position moved")

endmodule

[src/atsc_char_class.sv]
`timescale 1ns / 1ps

module atsc_char_class import atsc_pkg::*; (
   input  logic [CHAR_W-1:0] char_code,
   output char_class_type    cls
);

   logic upper;
   logic lower;

   always_comb begin
      upper           = (char_code >= 8'h41) && (char_code <= 8'h5A);
      lower           = (char_code >= 8'h61) && (char_code <= 8'h7A);
      cls.is_dot      = (char_code == CHAR_DOT);
      cls.is_colon    = (char_code == CHAR_COLON);
      cls.is_digit    = (char_code >= 8'h30) && (char_code <= 8'h39);
      cls.is_alpha    = upper || lower;
      cls.is_xdigit   = cls.is_digit
                        || ((char_code >= 8'h41) && (char_code <= 8'h46))
                        || ((char_code >= 8'h61) && (char_code <= 8'h66));
      cls.is_graph    = (char_code >= 8'h21) && (char_code <= 8'h7E);
      cls.digit_value = char_code[3:0];   // valid only when is_digit
   end

endmodule

[bench/tb_address_text_syntax_checker.sv]
`timescale 1ns / 1ps

module tb_address_text_syntax_checker;
   import atsc_pkg::*;

   // Longest text in characters; the block is built with the same value.
   localparam int TEXT_MAX = 255;

   // Limits of the three syntaxes as the predictor sees them.
   localparam int OCTET_LIMIT    = 255;
   localparam int OCTET_SPAN     = 3;    // digits allowed after the last dot
   localparam int QUAD_DOTS      = 3;
   localparam int QUAD_DOTS_SAT  = 7;
   localparam int GROUP_SPAN     = 4;    // hex digits allowed after the last colon
   localparam int GROUP_COLONS   = 7;
   localparam int COLONS_MIN     = 2;
   localparam int TLD_SPAN       = 3;

   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_WORDS   = 145;   // character and end words per phase
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int SETTLE_CYCLES = 3;     // end word result shows in the cycle after accept
   localparam int CYCLE_LIMIT   = 200000;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              eot;
   } text_word_t;

   typedef struct packed {
      logic [ERR_W-1:0] err_pos;
      kind_type         kind;
      logic             too_long;
   } verdict_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic              csr_wr_en;
   logic [MASK_W-1:0] csr_wr_data;

   atsc_req_if req_bus ();
   atsc_rsp_if rsp_bus ();

   address_text_syntax_checker #(
      .MAX_LEN(TEXT_MAX)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Stimulus and scoreboard storage.
   text_word_t        pending_words [$];
   verdict_t          verdicts_due [$];
   logic [CHAR_W-1:0] draft [$];
   text_word_t        next_word;
   verdict_t          due;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int hold_requests  = 0;
   int hold_served    = 0;
   int hold_left      = 0;
   int cycle_count    = 0;
   int fail_count     = 0;

   // Predictor copy of the block's register and per-text state.
   logic [MASK_W-1:0] check_mask;
   int   text_pos;
   logic text_overflow;
   // dotted quad checker
   int   dq_err, dq_dot_pos, dq_octet, dq_dots;
   logic dq_after_dot;
   // hostname checker
   int   hn_err, hn_dot_pos;
   logic hn_after_dot, hn_alpha_only;
   // colon-hex checker
   int   hx_err, hx_colon_pos, hx_gap_pos, hx_colons;
   logic hx_after_colon;

   string letters   = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
   string host_set  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789-";
   string hex_set   = "0123456789abcdefABCDEF";
   string specials  = ".:0aFz9-";

   function automatic logic in_span(input int c, input int lo, input int hi);
      return c >= lo && c <= hi;
   endfunction

   task automatic clear_text_state();
      text_pos       = 1;
      text_overflow  = 1'b0;
      dq_err         = 0;
      dq_after_dot   = 1'b1;
      dq_dot_pos     = 1;
      dq_octet       = 0;
      dq_dots        = 0;
      hn_err         = 0;
      hn_after_dot   = 1'b1;
      hn_alpha_only  = 1'b1;
      hn_dot_pos     = 1;
      hx_err         = 0;
      hx_after_colon = 1'b0;
      hx_colon_pos   = 0;
      hx_gap_pos     = 0;
      hx_colons      = 0;
   endtask

   // Runs one accepted word through the three checkers. An end word closes the
   // text: it produces the verdict and clears the per-text state.
   task automatic absorb_word(input logic [CHAR_W-1:0] code, input logic eot);
      int c, p, n, nv, e4, eh, e6, worst;
      logic is_dec, is_hex;
      verdict_t v;
      c = code;
      is_dec = in_span(c, 8'h30, 8'h39);
      is_hex = is_dec || in_span(c, 8'h41, 8'h46) || in_span(c, 8'h61, 8'h66);
      if (!eot) begin
         // Past the limit every character lands on the last position.
         if (text_pos <= TEXT_MAX) begin
            p = text_pos;
            text_pos++;
         end else begin
            p = TEXT_MAX;
            text_overflow = 1'b1;
         end

         // Dotted quad: first error latches, later characters are ignored.
         if (dq_err == 0) begin
            if (c == CHAR_DOT) begin
               if (dq_after_dot) begin
                  dq_err = p;
               end else begin
                  dq_after_dot = 1'b1;
                  dq_dot_pos   = p;
                  dq_octet     = 0;
                  if (dq_dots < QUAD_DOTS_SAT) dq_dots++;
               end
            end else begin
               dq_after_dot = 1'b0;
               if (!is_dec || p - dq_dot_pos > OCTET_SPAN) begin
                  dq_err = p;
               end else begin
                  nv = dq_octet * 10 + (c - 8'h30);
                  if (nv > OCTET_LIMIT) dq_err = p;
                  else dq_octet = nv;
               end
            end
         end

         // Hostname: any printable label character, dots between labels.
         if (hn_err == 0) begin
            if (c == CHAR_DOT) begin
               if (hn_after_dot) begin
                  hn_err = p;
               end else begin
                  hn_after_dot  = 1'b1;
                  hn_alpha_only = 1'b1;
                  hn_dot_pos    = p;
               end
            end else begin
               hn_after_dot = 1'b0;
               if (!in_span(c, 8'h21, 8'h7E)) hn_err = p;
               else if (!(in_span(c, 8'h41, 8'h5A) || in_span(c, 8'h61, 8'h7A)))
                  hn_alpha_only = 1'b0;
            end
         end

         // Colon-hex: a second double colon is an error at once.
         if (hx_err == 0) begin
            if (c == CHAR_COLON) begin
               if (hx_after_colon && hx_gap_pos != 0) begin
                  hx_err = p;
               end else begin
                  if (hx_after_colon) hx_gap_pos = p;
                  hx_after_colon = 1'b1;
                  hx_colon_pos   = p;
                  hx_colons++;
                  if (hx_colons > GROUP_COLONS) hx_err = p;
               end
            end else begin
               hx_after_colon = 1'b0;
               if (!is_hex || p - hx_colon_pos > GROUP_SPAN) hx_err = p;
            end
         end
      end else begin
         n = text_pos - 1;
         e4 = 0;
         eh = 0;
         e6 = 0;
         v.kind = KIND_NONE;
         if (check_mask[MASK_IPV4]) begin
            if (n == 0) e4 = 1;
            else if (dq_err != 0) e4 = dq_err;
            else if (dq_after_dot || dq_dots != QUAD_DOTS) e4 = n;
            if (e4 == 0) v.kind = KIND_IPV4;
         end
         if (v.kind == KIND_NONE && check_mask[MASK_HOST]) begin
            if (n == 0) eh = 1;
            else if (hn_err != 0) eh = hn_err;
            else if (hn_after_dot) eh = n;
            // last label must be letters only and at least two long
            else if (!hn_alpha_only) eh = hn_dot_pos;
            else if (hn_dot_pos != 1 && n + 1 < hn_dot_pos + TLD_SPAN) eh = hn_dot_pos;
            if (eh == 0) v.kind = KIND_HOST;
         end
         if (v.kind == KIND_NONE && check_mask[MASK_IPV6]) begin
            if (n == 0) e6 = 1;
            else if (hx_err != 0) e6 = hx_err;
            else if (hx_after_colon && hx_gap_pos != n) e6 = n;
            else if (hx_colons < COLONS_MIN) e6 = n;
            else if (hx_gap_pos == 0 && hx_colons < GROUP_COLONS) e6 = n;
            if (e6 == 0) v.kind = KIND_IPV6;
         end
         worst = 0;
         if (v.kind == KIND_NONE) begin
            worst = eh;
            if (e4 > worst) worst = e4;
            if (e6 > worst) worst = e6;
         end
         v.err_pos  = worst[ERR_W-1:0];
         v.too_long = text_overflow;
         verdicts_due.push_back(v);
         clear_text_state();
      end
   endtask

   // Queues the draft text followed by its end word; the end word's character is noise.
   task automatic send_draft();
      text_word_t w;
      foreach (draft[i]) begin
         w.code = draft[i];
         w.eot  = 1'b0;
         pending_words.push_back(w);
      end
      w.code = CHAR_W'($urandom_range(255));
      w.eot  = 1'b1;
      pending_words.push_back(w);
      draft.delete();
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
      send_draft();
   endtask

   task automatic add_hex_group();
      repeat ($urandom_range(1, 4)) draft.push_back(hex_set[$urandom_range(hex_set.len() - 1)]);
   endtask

   // Block is idle once nothing is queued, on the bus, or owed. Each look is
   // taken after the edge's updates have landed.
   task automatic wait_until_drained();
      do begin
         @(posedge clock);
         #1;
      end while (pending_words.size() != 0 || verdicts_due.size() != 0 || req_bus.valid);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Called while the block is idle and the clock has just risen.
   task automatic write_mask(input logic [MASK_W-1:0] m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      check_mask   = m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Driver: offers the next queued word whenever the bus slot is free,
   // idling at random; the predictor sees each word at its accept edge.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            absorb_word(req_bus.char_code, req_bus.end_of_text);
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_word = pending_words.pop_front();
               req_bus.valid       <= 1'b1;
               req_bus.char_code   <= next_word.code;
               req_bus.end_of_text <= next_word.eot;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long hold-off, counted here so the stimulus process never sleeps on it.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_requests) begin
         hold_served <= hold_served + 1;
         hold_left   <= HOLD_CYCLES;
      end
   end

   // Monitor: checks every accepted result against the oldest verdict owed.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (verdicts_due.size() == 0) begin
               $error("result word with no text pending: error_position %0d",
                      rsp_bus.error_position);
               fail_count++;
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_bus.error_position !== due.err_pos) begin
                  $error("error_position: expected %0d, got %0d",
                         due.err_pos, rsp_bus.error_position);
                  fail_count++;
               end
               if (rsp_bus.matched_kind !== due.kind) begin
                  $error("matched_kind: expected %0d, got %0d", due.kind, rsp_bus.matched_kind);
                  fail_count++;
               end
               if (rsp_bus.too_long !== due.too_long) begin
                  $error("too_long: expected %0d, got %0d", due.too_long, rsp_bus.too_long);
                  fail_count++;
               end
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("address_text_syntax_checker test failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [MASK_W-1:0] mask_plan [0:PHASE_COUNT-1];
      int phase_words, form, parts, len, left, right, idx;
      int value;

      req_bus.valid       = 1'b0;
      req_bus.char_code   = '0;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      csr_wr_en           = 1'b0;
      csr_wr_data         = '0;
      check_mask          = MASK_RESET;
      clear_text_state();
      // none, one at a time, all three, then pairs
      mask_plan = '{3'd0, 3'd1, 3'd2, 3'd4, 3'd7, 3'd3, 3'd6, 3'd5};

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed texts under the reset mask.
      send_string("");             // empty text fails every check at 1
      draft.push_back(8'h00);      // code zero is an ordinary bad character
      send_draft();
      draft.push_back(8'hFF);      // as is the top code
      send_draft();
      send_string("1.2.3.4");
      send_string(":");            // lone leading colon only caught at the end
      send_string("ab.c");         // one-letter top label fails at its dot
      send_string("::f");
      wait_until_drained();

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         write_mask(mask_plan[ph]);
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
            default: begin send_idle_pct = 13; recv_stall_pct = 13; end
         endcase

         // One text past the length limit, all letters.
         if (ph == 2) begin
            repeat (TEXT_MAX + 8) draft.push_back(letters[$urandom_range(letters.len() - 1)]);
            send_draft();
         end

         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            form = $urandom_range(99);
            if (form < 80) begin
               case (form % 3)
                  0: begin
                     // dotted quad, sometimes with the wrong number of dots
                     parts = ($urandom_range(7) == 0) ? $urandom_range(1, 6) : 4;
                     for (int k = 0; k < parts; k++) begin
                        if (k != 0) draft.push_back(CHAR_DOT);
                        if ($urandom_range(9) == 0) draft.push_back("0");
                        value = $urandom_range(OCTET_LIMIT);
                        if (value >= 100) draft.push_back(CHAR_W'(8'h30 + value / 100));
                        if (value >= 10) draft.push_back(CHAR_W'(8'h30 + (value / 10) % 10));
                        draft.push_back(CHAR_W'(8'h30 + value % 10));
                     end
                  end
                  1: begin
                     // hostname; top label mostly letters
                     parts = $urandom_range(1, 4);
                     for (int k = 0; k < parts; k++) begin
                        if (k != 0) draft.push_back(CHAR_DOT);
                        len = (k == parts - 1) ? $urandom_range(1, 6) : $urandom_range(1, 10);
                        repeat (len) begin
                           if (k == parts - 1 && $urandom_range(7) != 0)
                              draft.push_back(letters[$urandom_range(letters.len() - 1)]);
                           else
                              draft.push_back(host_set[$urandom_range(host_set.len() - 1)]);
                        end
                     end
                  end
                  default: begin
                     // colon-hex, full eight groups or with one gap
                     if ($urandom_range(2) == 0) begin
                        for (int k = 0; k < 8; k++) begin
                           if (k != 0) draft.push_back(CHAR_COLON);
                           add_hex_group();
                        end
                     end else begin
                        left  = $urandom_range(0, 6);
                        right = $urandom_range(0, 6 - left);
                        for (int k = 0; k < left; k++) begin
                           if (k != 0) draft.push_back(CHAR_COLON);
                           add_hex_group();
                        end
                        draft.push_back(CHAR_COLON);
                        draft.push_back(CHAR_COLON);
                        for (int k = 0; k < right; k++) begin
                           if (k != 0) draft.push_back(CHAR_COLON);
                           add_hex_group();
                        end
                     end
                  end
               endcase
               // a quarter of the well-formed texts get damaged
               if (form >= 60) begin
                  repeat ($urandom_range(1, 2)) begin
                     if (draft.size() != 0) begin
                        idx = $urandom_range(draft.size() - 1);
                        case ($urandom_range(2))
                           0: draft[idx] = CHAR_W'($urandom_range(255));
                           1: draft.insert(idx, draft[idx]);
                           default: draft.delete(idx);
                        endcase
                     end
                  end
               end
            end else begin
               // noise, now and then long enough to overflow
               len = ($urandom_range(79) == 0) ? $urandom_range(TEXT_MAX + 1, TEXT_MAX + 15)
                                               : $urandom_range(0, 12);
               repeat (len) begin
                  if ($urandom_range(1) == 0)
                     draft.push_back(CHAR_W'($urandom_range(255)));
                  else
                     draft.push_back(specials[$urandom_range(specials.len() - 1)]);
               end
            end
            phase_words += draft.size() + 1;
            send_draft();
         end

         // Receiver goes quiet while the words keep coming, so a held result
         // backs up into the input.
         if (ph == 4) hold_requests++;
         wait_until_drained();
      end

      if (fail_count == 0) begin
         $display("address_text_syntax_checker test passed");
      end else begin
         $display("address_text_syntax_checker test failed");
      end
      $finish;
   end

endmodule
